/* src/ffha_pkg.sv */
// Shared types and constants for the first-fit heap allocator.
// Used by the header RAM, the walk controller and the top level.
`default_nettype none
package ffha_pkg;

    // Word positions carry enough bits to step past the largest pool by one block.
    localparam int POS_W = 18;
    localparam int HDR_W = 17;

    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_ALLOC = 2'd1;
    localparam logic [1:0] CMD_FREE  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    localparam logic REG_POOL_WORDS = 1'b0;

    typedef struct packed {
        logic             rd;
        logic [POS_W-1:0] raddr;
        logic             wr;
        logic [POS_W-1:0] waddr;
        logic [HDR_W-1:0] wdata;
    } hdr_req_t;

    typedef struct packed {
        logic        ok;
        logic [11:0] payload_offset;
        logic [15:0] largest_bytes;
    } res_t;

endpackage
`default_nettype wire

/* src/ffha_hdr_ram.sv */
// Header store: one synchronous RAM, one write and one read port, registered read data.
// Depends on ffha_pkg for the request struct.
`default_nettype none
module ffha_hdr_ram
    import ffha_pkg::*;
#(
    parameter int POOL_WORDS = 4096
)
(
    input  wire logic             clk,
    input  wire hdr_req_t         req,
    output logic      [HDR_W-1:0] q
);
    localparam int AW = $clog2(POOL_WORDS);

    logic [HDR_W-1:0] mem [POOL_WORDS];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.rd)
        begin
            q <= mem[req.raddr[AW-1:0]];
        end
    end
endmodule
`default_nettype wire

/* src/ffha_ctrl.sv */
// Walk controller: runs init, allocate, free and query over the header RAM.
// Depends on ffha_pkg; drives ffha_hdr_ram through a request struct.
`default_nettype none
module ffha_ctrl
    import ffha_pkg::*;
#(
    parameter int POOL_WORDS   = 4096,
    parameter int HEADER_WORDS = 1,
    parameter int WORD_BYTES   = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic [1:0]       cmd,
    input  wire logic [15:0]      request_bytes,
    input  wire logic [11:0]      block_offset,
    input  wire logic [12:0]      pool_words,
    output logic                  idle,
    output logic                  done,
    output res_t                  res,
    input  wire logic             res_take,
    output hdr_req_t              req,
    input  wire logic [HDR_W-1:0] rdata_raw
);
    localparam int WBL = $clog2(WORD_BYTES);
    localparam logic [POS_W-1:0] POOL_POS  = POS_W'(POOL_WORDS);
    localparam logic [POS_W-1:0] HW_POS    = POS_W'(HEADER_WORDS);
    localparam logic [HDR_W-1:0] HW_HDR    = HDR_W'(HEADER_WORDS);
    localparam logic [POS_W-1:0] MIN_POOL  = POS_W'(2 * HEADER_WORDS + 2);
    localparam logic [HDR_W-1:0] MIN_SPLIT = HDR_W'(HEADER_WORDS + 1);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_INIT2     = 4'd1;
    localparam logic [3:0] S_CUR_WAIT  = 4'd2;
    localparam logic [3:0] S_NXT_WAIT  = 4'd3;
    localparam logic [3:0] S_EVAL      = 4'd4;
    localparam logic [3:0] S_HDR_WR    = 4'd5;
    localparam logic [3:0] S_FREE_WAIT = 4'd6;
    localparam logic [3:0] S_DONE      = 4'd7;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       cmd_reg, cmd_next;
    logic [HDR_W-1:0] words_reg, words_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] nxt_reg, nxt_next;
    logic [HDR_W-1:0] cur_reg, cur_next;
    logic [15:0]      best_reg, best_next;
    logic             oob_reg, oob_next;
    res_t             res_reg, res_next;

    logic [HDR_W-1:0]  rdata;
    logic [POS_W-1:0]  cur_ext, mag_cur, adv_pos, rd_ext, nn_pos, pw_pos, first_pos;
    logic [HDR_W-1:0]  merged, rest, in_words;
    logic [16+WBL-1:0] best_bytes;
    logic              cur_pos, fit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            oob_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            oob_reg   <= oob_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        words_reg <= words_next;
        pos_reg   <= pos_next;
        nxt_reg   <= nxt_next;
        cur_reg   <= cur_next;
        best_reg  <= best_next;
        res_reg   <= res_next;
    end

    always_comb
    begin
        // Positions at or beyond the pool read as an end marker.
        rdata      = oob_reg ? '0 : rdata_raw;
        cur_ext    = {cur_reg[HDR_W-1], cur_reg};
        mag_cur    = cur_reg[HDR_W-1] ? POS_W'(-cur_ext) : cur_ext;
        adv_pos    = pos_reg + mag_cur + HW_POS;
        rd_ext     = {rdata[HDR_W-1], rdata};
        nn_pos     = nxt_reg + rd_ext + HW_POS;
        merged     = cur_reg + rdata + HW_HDR;
        cur_pos    = (cur_reg != '0) && !cur_reg[HDR_W-1];
        fit        = (cmd_reg == CMD_ALLOC) && cur_pos && (cur_reg >= words_reg);
        rest       = cur_reg - words_reg;
        best_bytes = {best_reg, {WBL{1'b0}}};
        in_words   = ({1'b0, request_bytes} + HDR_W'(WORD_BYTES - 1)) >> WBL;
        pw_pos     = POS_W'(pool_words);
        if (pw_pos < MIN_POOL)
        begin
            pw_pos = MIN_POOL;
        end
        if (pw_pos > POOL_POS)
        begin
            pw_pos = POOL_POS;
        end
        first_pos  = pw_pos - POS_W'(2 * HEADER_WORDS);

        state_next = state_reg;
        cmd_next   = cmd_reg;
        words_next = words_reg;
        pos_next   = pos_reg;
        nxt_next   = nxt_reg;
        cur_next   = cur_reg;
        best_next  = best_reg;
        oob_next   = oob_reg;
        res_next   = res_reg;
        req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    words_next = in_words;
                    best_next  = '0;
                    res_next   = '{ok: 1'b1, payload_offset: '0, largest_bytes: '0};
                    pos_next   = '0;
                    unique case (cmd)
                        CMD_INIT:
                        begin
                            req.wr     = 1'b1;
                            req.waddr  = '0;
                            req.wdata  = HDR_W'(first_pos);
                            pos_next   = first_pos + HW_POS;
                            state_next = S_INIT2;
                        end
                        CMD_FREE:
                        begin
                            if (block_offset < 12'(HEADER_WORDS))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                pos_next   = POS_W'(block_offset - 12'(HEADER_WORDS));
                                req.raddr  = POS_W'(block_offset - 12'(HEADER_WORDS));
                                req.rd     = req.raddr < POOL_POS;
                                oob_next   = !req.rd;
                                state_next = S_FREE_WAIT;
                            end
                        end
                        default:
                        begin
                            if (cmd == CMD_ALLOC && in_words == '0)
                            begin
                                res_next.ok = 1'b0;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                req.rd     = 1'b1;
                                req.raddr  = '0;
                                oob_next   = 1'b0;
                                state_next = S_CUR_WAIT;
                            end
                        end
                    endcase
                end
            end
            S_INIT2:
            begin
                req.wr     = 1'b1;
                req.waddr  = pos_reg;
                req.wdata  = '0;
                state_next = S_DONE;
            end
            S_CUR_WAIT:
            begin
                cur_next = rdata;
                if (rdata == '0)
                begin
                    if (cmd_reg == CMD_ALLOC)
                    begin
                        res_next.ok = 1'b0;
                    end
                    else if (best_bytes[16+WBL-1:16] != '0)
                    begin
                        res_next.largest_bytes = 16'hFFFF;
                    end
                    else
                    begin
                        res_next.largest_bytes = best_bytes[15:0];
                    end
                    state_next = S_DONE;
                end
                else if (!rdata[HDR_W-1])
                begin
                    // Free block: look at the block behind it for merging.
                    nxt_next   = pos_reg + rd_ext + HW_POS;
                    req.raddr  = pos_reg + rd_ext + HW_POS;
                    req.rd     = req.raddr < POOL_POS;
                    oob_next   = !req.rd;
                    state_next = S_NXT_WAIT;
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_NXT_WAIT:
            begin
                if (rdata != '0 && !rdata[HDR_W-1])
                begin
                    req.wr    = 1'b1;
                    req.waddr = pos_reg;
                    req.wdata = merged;
                    cur_next  = merged;
                    nxt_next  = nn_pos;
                    if (merged != '0 && !merged[HDR_W-1])
                    begin
                        req.raddr = nn_pos;
                        req.rd    = nn_pos < POOL_POS;
                        oob_next  = !req.rd;
                    end
                    else
                    begin
                        state_next = S_EVAL;
                    end
                end
                else
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (fit)
                begin
                    if (rest < MIN_SPLIT)
                    begin
                        words_next = cur_reg;
                    end
                    else
                    begin
                        req.waddr = pos_reg + HW_POS + POS_W'(words_reg);
                        req.wr    = req.waddr < POOL_POS;
                        req.wdata = rest - HW_HDR;
                    end
                    state_next = S_HDR_WR;
                end
                else
                begin
                    if (cmd_reg == CMD_QUERY && cur_pos && cur_reg[15:0] > best_reg)
                    begin
                        best_next = cur_reg[15:0];
                    end
                    pos_next   = adv_pos;
                    req.raddr  = adv_pos;
                    req.rd     = adv_pos < POOL_POS;
                    oob_next   = !req.rd;
                    state_next = S_CUR_WAIT;
                end
            end
            S_HDR_WR:
            begin
                req.wr     = 1'b1;
                req.waddr  = pos_reg;
                req.wdata  = HDR_W'(-words_reg);
                res_next.payload_offset = 12'(pos_reg + HW_POS);
                state_next = S_DONE;
            end
            S_FREE_WAIT:
            begin
                req.wr     = !oob_reg;
                req.waddr  = pos_reg;
                req.wdata  = HDR_W'(-rdata);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);
    assign res  = res_reg;
endmodule
`default_nettype wire

/* src/first_fit_heap_allocator_unit.sv */
// First-fit heap allocator: init writes the first block header and the end marker; free reads
// the block header and writes it back as free; an ignored free or a zero-byte allocate finishes
// without a header access. Allocate and query read each header in turn, read the header behind
// a free block and merge free neighbours. One transaction at a time; the result is registered.
// Reset clears control state and sets pool_words to 4096; the header RAM is not cleared
// and holds nothing valid until an init. Depends on ffha_pkg, ffha_ctrl, ffha_hdr_ram.
`default_nettype none
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
#(
    parameter int POOL_WORDS   = 4096,
    parameter int HEADER_WORDS = 1,
    parameter int WORD_BYTES   = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  cmd,
    input  wire logic [15:0] request_bytes,
    input  wire logic [11:0] block_offset,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             ok,
    output logic      [11:0] payload_offset,
    output logic      [15:0] largest_bytes
);
    logic [12:0]      pool_words_reg;
    logic             out_valid_reg;
    res_t             out_reg;
    logic             idle, done, res_take;
    res_t             res;
    hdr_req_t         req;
    logic [HDR_W-1:0] rdata_raw;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POOL_WORDS) ? {19'd0, pool_words_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_words_reg <= 13'd4096;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_POOL_WORDS)
        begin
            pool_words_reg <= pwdata[12:0];
        end
    end

    // The result waits in the output register while the controller returns to idle.
    assign res_take = done && (!out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    ffha_ctrl #(
        .POOL_WORDS  (POOL_WORDS),
        .HEADER_WORDS(HEADER_WORDS),
        .WORD_BYTES  (WORD_BYTES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .cmd          (cmd),
        .request_bytes(request_bytes),
        .block_offset (block_offset),
        .pool_words   (pool_words_reg),
        .idle         (idle),
        .done         (done),
        .res          (res),
        .res_take     (res_take),
        .req          (req),
        .rdata_raw    (rdata_raw)
    );

    ffha_hdr_ram #(
        .POOL_WORDS(POOL_WORDS)
    ) u_ram (
        .clk(clk),
        .req(req),
        .q  (rdata_raw)
    );

    assign in_stall       = !idle;
    assign out_valid      = out_valid_reg;
    assign ok             = out_reg.ok;
    assign payload_offset = out_reg.payload_offset;
    assign largest_bytes  = out_reg.largest_bytes;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("block took a second transaction while busy");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(res_take && out_valid_reg && out_stall))
        else $error("result overwrote a stalled output");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr && req.rd && req.waddr == req.raddr))
        else $error("header read and write hit the same entry");
endmodule
`default_nettype wire
